// File: hw/rtl/tsrd_pkg.sv
// Shared types and constants for the timestamp response deframer.
// Used by every module of the block; no dependencies of its own.
package tsrd_pkg;

  localparam int unsigned MAX_RESPONSE_BYTES = 65536;
  localparam int unsigned CNT_W = $clog2(MAX_RESPONSE_BYTES + 1);

  // command codes
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_NEW   = 2'd2;

  // outcome codes
  localparam logic [3:0] OC_SUCCESS    = 4'd0;
  localparam logic [3:0] OC_ERRMSG     = 4'd1;
  localparam logic [3:0] OC_POLL       = 4'd2;
  localparam logic [3:0] OC_NEGPOLL    = 4'd3;
  localparam logic [3:0] OC_PARTIAL    = 4'd4;
  localparam logic [3:0] OC_UNEXPECTED = 4'd5;
  localparam logic [3:0] OC_MALFORMED  = 4'd6;
  localparam logic [3:0] OC_PREMATURE  = 4'd7;
  localparam logic [3:0] OC_ZEROLEN    = 4'd8;
  localparam logic [3:0] OC_TOOLARGE   = 4'd9;

  // frame flag values
  localparam logic [7:0] FLAG_POLLREP  = 8'h01;
  localparam logic [7:0] FLAG_NEGPOLL  = 8'h03;
  localparam logic [7:0] FLAG_PARTIAL  = 8'h04;
  localparam logic [7:0] FLAG_SUCCESS  = 8'h05;
  localparam logic [7:0] FLAG_ERRMSG   = 8'h06;

  // configuration register indexes
  localparam logic [1:0] REG_AFTER = 2'd0;
  localparam logic [1:0] REG_BASE  = 2'd1;
  localparam logic [1:0] REG_MAX   = 2'd2;

  localparam logic [3:0] MAX_SHIFT = 4'd9;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]  backoff_after_polls;
    logic [7:0]  backoff_base_sec;
    logic [11:0] max_interval_sec;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  outcome;
    logic [7:0]  frame_flag;
    logic [15:0] payload_length;
    logic [31:0] poll_reference;
    logic [11:0] poll_delay_sec;
  } result_t;

endpackage

// File: hw/rtl/tsrd_in_stage.sv
// Input register of the deframer: holds one request until the core takes it.
// Depends on tsrd_pkg.
module tsrd_in_stage
  import tsrd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  take_i,
  output logic  item_valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// File: hw/rtl/tsrd_poll_delay.sv
// Poll delay: check-back time with a doubling floor past the poll threshold,
// capped at the configured maximum. Depends on tsrd_pkg.
module tsrd_poll_delay
  import tsrd_pkg::*;
(
  input  cfg_t        cfg_i,
  input  logic [7:0]  polls_i,
  input  logic [31:0] check_back_i,
  output logic [11:0] delay_o
);

  logic        past_thr;
  logic [7:0]  over;
  logic [3:0]  shamt;
  logic [16:0] floor_sec;
  logic [31:0] floored;

  always_comb begin
    past_thr  = polls_i > cfg_i.backoff_after_polls;
    over      = polls_i - cfg_i.backoff_after_polls - 8'd1;
    shamt     = (over > 8'(MAX_SHIFT)) ? MAX_SHIFT : over[3:0];
    floor_sec = {9'd0, cfg_i.backoff_base_sec} << shamt;
    floored   = check_back_i;
    if (past_thr && ({15'd0, floor_sec} > check_back_i)) begin
      floored = {15'd0, floor_sec};
    end
    if (floored > {20'd0, cfg_i.max_interval_sec}) begin
      delay_o = cfg_i.max_interval_sec;
    end else begin
      delay_o = floored[11:0];
    end
  end

endmodule

// File: hw/rtl/tsrd_frame_core.sv
// Frame state and classification: byte counting, field capture, close
// handling and poll bookkeeping. Depends on tsrd_pkg and tsrd_poll_delay.
module tsrd_frame_core
  import tsrd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output logic    res_valid_o,
  output result_t res_o
);

  logic             active_q, active_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [31:0]      flen_q, flen_d;
  logic [7:0]       flag_q, flag_d;
  logic [31:0]      ref_q, ref_d;
  logic [31:0]      cb_q, cb_d;
  logic [7:0]       polls_q, polls_d;

  logic [7:0]  polls_inc;
  logic [11:0] delay;
  logic [3:0]  class_oc;
  logic [31:0] flen_m1;
  logic [15:0] plen;
  logic [7:0]  flag_out;
  logic        have_len;

  assign polls_inc = (polls_q == 8'hFF) ? polls_q : polls_q + 8'd1;

  tsrd_poll_delay u_delay (
    .cfg_i       (cfg_i),
    .polls_i     (polls_inc),
    .check_back_i(cb_q),
    .delay_o     (delay)
  );

  always_comb begin
    have_len = count_q >= CNT_W'(4);
    flen_m1  = flen_q - 32'd1;
    plen     = 16'd0;
    if (have_len && (flen_q != 32'd0)) begin
      plen = (|flen_m1[31:16]) ? 16'hFFFF : flen_m1[15:0];
    end
    flag_out = (count_q >= CNT_W'(5)) ? flag_q : 8'd0;

    if (!have_len) begin
      class_oc = OC_PREMATURE;
    end else if (flen_q == 32'd0) begin
      class_oc = OC_ZEROLEN;
    end else if ({{(33-CNT_W){1'b0}}, count_q} < ({1'b0, flen_q} + 33'd4)) begin
      class_oc = OC_PREMATURE;
    end else begin
      case (flag_q)
        FLAG_SUCCESS: class_oc = OC_SUCCESS;
        FLAG_ERRMSG:  class_oc = OC_ERRMSG;
        FLAG_POLLREP: class_oc = (flen_q < 32'd9) ? OC_MALFORMED : OC_POLL;
        FLAG_NEGPOLL: class_oc = OC_NEGPOLL;
        FLAG_PARTIAL: class_oc = OC_PARTIAL;
        default:      class_oc = OC_UNEXPECTED;
      endcase
    end
  end

  always_comb begin
    active_d = active_q;
    count_d  = count_q;
    flen_d   = flen_q;
    flag_d   = flag_q;
    ref_d    = ref_q;
    cb_d     = cb_q;
    polls_d  = polls_q;
    res_valid_o          = 1'b0;
    res_o.outcome        = class_oc;
    res_o.frame_flag     = flag_out;
    res_o.payload_length = plen;
    res_o.poll_reference = 32'd0;
    res_o.poll_delay_sec = 12'd0;

    if (en_i) begin
      if (item_i.command == CMD_NEW) begin
        active_d = 1'b1;
        count_d  = '0;
        flen_d   = 32'd0;
        flag_d   = 8'd0;
        ref_d    = 32'd0;
        cb_d     = 32'd0;
        polls_d  = 8'd0;
      end else if (active_q && item_i.command == CMD_BYTE) begin
        if (count_q >= CNT_W'(MAX_RESPONSE_BYTES)) begin
          res_valid_o   = 1'b1;
          res_o.outcome = OC_TOOLARGE;
          active_d      = 1'b0;
        end else begin
          // capture position follows the byte count only
          if (count_q < CNT_W'(4)) begin
            flen_d = {flen_q[23:0], item_i.rx_byte};
          end else if (count_q == CNT_W'(4)) begin
            flag_d = item_i.rx_byte;
          end else if (count_q < CNT_W'(9)) begin
            ref_d = {ref_q[23:0], item_i.rx_byte};
          end else if (count_q < CNT_W'(13)) begin
            cb_d = {cb_q[23:0], item_i.rx_byte};
          end
          count_d = count_q + CNT_W'(1);
        end
      end else if (active_q && item_i.command == CMD_CLOSE) begin
        res_valid_o = 1'b1;
        if (class_oc == OC_POLL) begin
          polls_d              = polls_inc;
          res_o.poll_reference = ref_q;
          res_o.poll_delay_sec = delay;
          count_d = '0;
          flen_d  = 32'd0;
          flag_d  = 8'd0;
          ref_d   = 32'd0;
          cb_d    = 32'd0;
        end else begin
          active_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b1;
      count_q  <= '0;
      flen_q   <= 32'd0;
      flag_q   <= 8'd0;
      ref_q    <= 32'd0;
      cb_q     <= 32'd0;
      polls_q  <= 8'd0;
    end else begin
      active_q <= active_d;
      count_q  <= count_d;
      flen_q   <= flen_d;
      flag_q   <= flag_d;
      ref_q    <= ref_d;
      cb_q     <= cb_d;
      polls_q  <= polls_d;
    end
  end

endmodule

// File: hw/rtl/timestamp_tcp_response_deframer_core.sv
// Timestamp response deframer, top level: input register, frame core,
// result register and configuration registers. Depends on tsrd_pkg.
// Requests pass the input register and the core; results leave the result
// register. Throughput: one request per cycle, single-pass core, unless stalled.
// Reset: asynchronous, active low; returns to receiving with empty captures,
// zero poll count and default configuration (after 8, base 1 s, max 300 s).
module timestamp_tcp_response_deframer_core
  import tsrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] frame_flag, [23:8] payload_length, [55:24] poll_reference,
  // [67:56] poll_delay_sec, [71:68] zero
  output logic [71:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser,   // [3:0] outcome
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i
);

  cfg_t    cfg_q, cfg_d;
  item_t   in_item, cur_item;
  logic    cur_valid, advance;
  logic    core_valid;
  result_t core_res;
  logic    out_valid_q, out_valid_d;
  result_t out_res_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AFTER: cfg_d.backoff_after_polls = cfg_data_i[7:0];
        REG_BASE:  cfg_d.backoff_base_sec    = cfg_data_i[7:0];
        REG_MAX:   cfg_d.max_interval_sec    = cfg_data_i;
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.backoff_after_polls <= 8'd8;
      cfg_q.backoff_base_sec    <= 8'd1;
      cfg_q.max_interval_sec    <= 12'd300;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_item.command = s_axis_tuser;
  assign in_item.rx_byte = s_axis_tdata;

  // the core moves whenever the result register is free or being drained
  assign advance = !out_valid_q || m_axis_tready;

  tsrd_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .take_i      (advance),
    .item_valid_o(cur_valid),
    .item_o      (cur_item)
  );

  tsrd_frame_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (cur_valid && advance),
    .item_i     (cur_item),
    .cfg_i      (cfg_q),
    .res_valid_o(core_valid),
    .res_o      (core_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = cur_valid && core_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && cur_valid && core_valid) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.outcome;
  assign m_axis_tdata  = {4'd0, out_res_q.poll_delay_sec, out_res_q.poll_reference,
                          out_res_q.payload_length, out_res_q.frame_flag};

endmodule

// File: hw/rtl/tsrd_checker.sv
// Port-level checks for the deframer top level, attached by bind.
// Depends on tsrd_pkg and timestamp_tcp_response_deframer_core.
module tsrd_checker
  import tsrd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_outcome_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= OC_TOOLARGE)
    else $error("outcome code out of range");

  a_poll_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != OC_POLL |-> m_axis_tdata[71:24] == 48'd0)
    else $error("poll fields set on a non-poll result");

  a_zerolen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == OC_ZEROLEN |-> m_axis_tdata[23:8] == 16'd0)
    else $error("zero-length frame with nonzero payload length");

endmodule

bind timestamp_tcp_response_deframer_core tsrd_checker u_tsrd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
